// File: hw/rtl/tme_pkg.sv
// shared types and constants for the transform matrix engine
`default_nettype none

package tme_pkg;

  localparam int COORD_W    = 32;
  localparam int OP_W       = 3;
  localparam int IDX_W      = 4;
  localparam int N_ELEM     = 16;
  localparam int N_ROWS     = 4;
  localparam int IN_DATA_W  = 136;
  localparam int OUT_DATA_W = 96;

  typedef enum logic [OP_W-1:0] {
    OP_IDENTITY  = 3'd0,
    OP_WRITE     = 3'd1,
    OP_TRANSLATE = 3'd2,
    OP_SCALE     = 3'd3,
    OP_TRANSFORM = 3'd4
  } op_e;

endpackage

`default_nettype wire

// File: hw/rtl/tme_sat.sv
// signed saturating resize from one width to another
`default_nettype none

module tme_sat #(
  parameter int IW = 32,
  parameter int OW = 32
) (
  input  logic signed [IW-1:0] a_i,
  output logic signed [OW-1:0] y_o
);

  localparam int MW = (IW > OW) ? IW : OW;

  logic signed [MW-1:0] a_ext;
  logic signed [MW-1:0] lim_hi;
  logic signed [MW-1:0] lim_lo;

  assign a_ext  = MW'(a_i);
  assign lim_hi = MW'({1'b0, {(OW-1){1'b1}}});
  assign lim_lo = ~lim_hi;

  always_comb begin
    if (a_ext > lim_hi) begin
      y_o = lim_hi[OW-1:0];
    end else if (a_ext < lim_lo) begin
      y_o = lim_lo[OW-1:0];
    end else begin
      y_o = a_ext[OW-1:0];
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/tme_fx_mul.sv
// fixed-point multiply: exact product, floor shift, saturate to element width
`default_nettype none

module tme_fx_mul
  import tme_pkg::*;
#(
  parameter int VALUE_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic signed [COORD_W-1:0]     a_i,
  input  logic signed [VALUE_WIDTH-1:0] b_i,
  output logic signed [VALUE_WIDTH-1:0] y_o
);

  localparam int PW = COORD_W + VALUE_WIDTH;

  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] shifted;

  assign prod    = PW'(a_i) * PW'(b_i);
  // arithmetic shift gives floor for negative products
  assign shifted = prod >>> FRAC_BITS;

  tme_sat #(
    .IW (PW),
    .OW (VALUE_WIDTH)
  ) u_sat (
    .a_i (shifted),
    .y_o (y_o)
  );

endmodule

`default_nettype wire

// File: hw/rtl/tme_datapath.sv
// product array and column sums shared by translate, scale and transform
`default_nettype none

module tme_datapath
  import tme_pkg::*;
#(
  parameter int VALUE_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic signed [COORD_W-1:0]     x_i,
  input  logic signed [COORD_W-1:0]     y_i,
  input  logic signed [COORD_W-1:0]     z_i,
  input  logic signed [VALUE_WIDTH-1:0] mat_i    [N_ELEM],
  output logic signed [VALUE_WIDTH-1:0] prod_o   [N_ELEM],
  output logic signed [VALUE_WIDTH-1:0] colsum_o [N_ROWS]
);

  localparam int SW = VALUE_WIDTH + 2;

  logic signed [COORD_W-1:0] coord [N_ROWS-1];
  logic signed [SW-1:0]      sum   [N_ROWS];

  assign coord[0] = x_i;
  assign coord[1] = y_i;
  assign coord[2] = z_i;

  // row r of the upper three rows is multiplied by coordinate r
  for (genvar r = 0; r < N_ROWS - 1; r++) begin : g_row
    for (genvar c = 0; c < N_ROWS; c++) begin : g_col
      tme_fx_mul #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
      ) u_mul (
        .a_i (coord[r]),
        .b_i (mat_i[N_ROWS*r+c]),
        .y_o (prod_o[N_ROWS*r+c])
      );
    end
  end

  // bottom row has no product
  for (genvar c = 0; c < N_ROWS; c++) begin : g_sum
    assign prod_o[N_ROWS*(N_ROWS-1)+c] = mat_i[N_ROWS*(N_ROWS-1)+c];

    assign sum[c] = SW'(prod_o[c]) + SW'(prod_o[N_ROWS+c])
                  + SW'(prod_o[2*N_ROWS+c]) + SW'(mat_i[3*N_ROWS+c]);

    tme_sat #(
      .IW (SW),
      .OW (VALUE_WIDTH)
    ) u_sat (
      .a_i (sum[c]),
      .y_o (colsum_o[c])
    );
  end

endmodule

`default_nettype wire

// File: hw/rtl/transform_matrix_engine.sv
// a transform point result goes from the input register to the result register that drives the master side
// throughput: one item per cycle unless a transform finds the result register stalled; the full
//   product array and column sums sit between the input register and the matrix and result
//   registers, so every op completes in one pass; matrix ops give no result and update the matrix
// reset: asynchronous active low; clears the valid flags and loads the identity matrix
`default_nettype none

module transform_matrix_engine
  import tme_pkg::*;
#(
  parameter int VALUE_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // elem_index, elem_value, coord_x, coord_y, coord_z, zero fill
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  // op
  input  logic [OP_W-1:0]       s_axis_tuser_i,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // out_x, out_y, out_z
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o
);

  localparam logic signed [VALUE_WIDTH-1:0] ONE =
    (FRAC_BITS <= VALUE_WIDTH - 2) ? (VALUE_WIDTH'(1) << FRAC_BITS)
                                   : {1'b0, {(VALUE_WIDTH-1){1'b1}}};

  logic                          in_valid_q, in_valid_d;
  op_e                           op_q;
  logic [IDX_W-1:0]              idx_q;
  logic signed [COORD_W-1:0]     val_q, x_q, y_q, z_q;
  logic signed [VALUE_WIDTH-1:0] mat_q    [N_ELEM];
  logic signed [VALUE_WIDTH-1:0] mat_d    [N_ELEM];
  logic signed [VALUE_WIDTH-1:0] prod     [N_ELEM];
  logic signed [VALUE_WIDTH-1:0] colsum   [N_ROWS];
  logic signed [COORD_W-1:0]     out_w    [N_ROWS-1];
  logic signed [VALUE_WIDTH-1:0] wval;
  logic                          out_valid_q, out_valid_d;
  logic signed [COORD_W-1:0]     out_x_q, out_y_q, out_z_q;
  logic                          in_accept;
  logic                          advance;
  logic                          is_xform;

  assign is_xform = (op_q == OP_TRANSFORM);
  // a transform needs room in the result register, other ops always retire
  assign advance  = in_valid_q && (!is_xform || !out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign in_accept = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (advance) begin
      in_valid_d = 1'b0;
    end
    if (in_accept) begin
      in_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q  <= op_e'(s_axis_tuser_i);
      idx_q <= s_axis_tdata_i[3:0];
      val_q <= s_axis_tdata_i[35:4];
      x_q   <= s_axis_tdata_i[67:36];
      y_q   <= s_axis_tdata_i[99:68];
      z_q   <= s_axis_tdata_i[131:100];
    end
  end

  tme_datapath #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_datapath (
    .x_i      (x_q),
    .y_i      (y_q),
    .z_i      (z_q),
    .mat_i    (mat_q),
    .prod_o   (prod),
    .colsum_o (colsum)
  );

  tme_sat #(
    .IW (COORD_W),
    .OW (VALUE_WIDTH)
  ) u_wsat (
    .a_i (val_q),
    .y_o (wval)
  );

  for (genvar c = 0; c < N_ROWS - 1; c++) begin : g_out
    tme_sat #(
      .IW (VALUE_WIDTH),
      .OW (COORD_W)
    ) u_osat (
      .a_i (colsum[c]),
      .y_o (out_w[c])
    );
  end

  always_comb begin
    mat_d = mat_q;
    if (advance) begin
      unique case (op_q)
        OP_IDENTITY: begin
          for (int i = 0; i < N_ELEM; i++) begin
            mat_d[i] = (i == 0 || i == 5 || i == 10 || i == 15) ? ONE : '0;
          end
        end
        OP_WRITE: begin
          mat_d[idx_q] = wval;
        end
        OP_TRANSLATE: begin
          for (int c = 0; c < N_ROWS; c++) begin
            mat_d[N_ROWS*(N_ROWS-1)+c] = colsum[c];
          end
        end
        OP_SCALE: begin
          // bottom row of the product array is the unchanged matrix row
          mat_d = prod;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < N_ELEM; i++) begin
        mat_q[i] <= (i == 0 || i == 5 || i == 10 || i == 15) ? ONE : '0;
      end
    end else begin
      mat_q <= mat_d;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
    if (advance && is_xform) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && is_xform) begin
      out_x_q <= out_w[0];
      out_y_q <= out_w[1];
      out_z_q <= out_w[2];
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_z_q, out_y_q, out_x_q};

endmodule

`default_nettype wire

// File: hw/rtl/tme_checker.sv
// port-level checks for the transform matrix engine and their bind
`default_nettype none

module tme_checker
  import tme_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tvalid_i,
  input logic                  s_axis_tready_o,
  input logic [OP_W-1:0]       s_axis_tuser_i,
  input logic                  m_axis_tvalid_o,
  input logic                  m_axis_tready_i,
  input logic [OUT_DATA_W-1:0] m_axis_tdata_o
);

  // an empty result register never blocks the slave side
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("slave side stalled with empty result register");

  // a new result comes from an accepted transform transaction by way of the input register
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |->
      $past(s_axis_tvalid_i && s_axis_tready_o && (s_axis_tuser_i == OP_TRANSFORM), 2))
    else $error("result without a matching transform transaction");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |-> !m_axis_tvalid_o)
    else $error("result valid during reset");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled result changed");

endmodule

bind transform_matrix_engine tme_checker u_tme_checker (.*);

`default_nettype wire
